FILE: sv/urtb_pkg.sv
// Shared constants, codes and index helpers for the UART ring buffer block.
package urtb_pkg;

  localparam int RX_DEPTH = 8;
  localparam int TX_DEPTH = 8;

  localparam int RX_IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_FW = $clog2(RX_DEPTH + 1);
  localparam int TX_FW = $clog2(TX_DEPTH + 1);

  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic [1:0] FUNC_LINE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_TXRDY = 2'd3;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RXPOP = 2'd2;
  localparam logic [1:0] S_TXPOP = 2'd3;

  typedef logic [RX_IW-1:0] rx_idx_t;
  typedef logic [TX_IW-1:0] tx_idx_t;
  typedef logic [RX_FW-1:0] rx_cnt_t;
  typedef logic [TX_FW-1:0] tx_cnt_t;

  function automatic rx_idx_t rx_next(input rx_idx_t i);
    return (i == RX_IW'(RX_DEPTH - 1)) ? '0 : i + RX_IW'(1);
  endfunction

  function automatic tx_idx_t tx_next(input tx_idx_t i);
    return (i == TX_IW'(TX_DEPTH - 1)) ? '0 : i + TX_IW'(1);
  endfunction

endpackage

FILE: sv/urtb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module urtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/uart_rx_tx_ring_buffers.sv
// Top level: UART receive and transmit ring buffers around two small RAMs.
//
//   channel | direction | handshake            | contents
//   --------+-----------+----------------------+------------------------------------------
//   in_     | request   | in_valid / in_ready  | func, line byte, write byte, read count
//   out_    | result    | out_valid / out_ready| popped byte, flags, both levels, CR, irq
//
// Sequencing: a request is taken in the idle state and executed from the EXEC state, so
// a single-result request (line byte, host write, empty read, idle transmitter
// event) is answered from EXEC. Requests that pop first read the RAM from EXEC:
// a host read of n bytes then pops one byte a cycle out of the receive RAM while
// the output is not stalled, and a transmit pop answers from its own pop state.
// Reset clears pointers, fill counts, the CR count and the irq enable; the RAM
// contents are never cleared and only entries that were written are read.
// A stalled result holds in the output register; execution waits on it, and
// the popped RAM word stays in the RAM read register until it can move on.
module uart_rx_tx_ring_buffers (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_line_byte,
  input  logic [7:0] in_write_byte,
  input  logic [6:0] in_max_count,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_accepted,
  output logic       out_dropped,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic [6:0] out_rx_level,
  output logic [7:0] out_tx_level,
  output logic       out_line_ready,
  output logic       out_tx_irq_enable
);

  // Control state.
  logic [1:0]          state_r, state_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [7:0]          data_r, data_nxt;
  logic [6:0]          maxc_r, maxc_nxt;
  urtb_pkg::rx_idx_t   rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  urtb_pkg::tx_idx_t   tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  urtb_pkg::rx_cnt_t   rx_fill_r, rx_fill_nxt;
  urtb_pkg::rx_cnt_t   rx_cr_r, rx_cr_nxt;   // CR bytes held in the receive FIFO
  urtb_pkg::rx_cnt_t   rem_r, rem_nxt;       // bytes left to pop on a host read
  urtb_pkg::tx_cnt_t   tx_fill_r, tx_fill_nxt;
  logic                irq_r, irq_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] res_byte_r, res_tx_byte_r;
  logic       res_bv_r, res_last_r, res_acc_r, res_drop_r, res_tv_r, res_lr_r, res_irq_r;
  logic [6:0] res_rxl_r;
  logic [7:0] res_txl_r;

  // Result being built this cycle.
  logic       load_out;
  logic [7:0] c_byte, c_tx_byte;
  logic       c_bv, c_last, c_acc, c_drop, c_tv;

  // RAM ports.
  logic              rx_we, rx_re, tx_we, tx_re;
  urtb_pkg::rx_idx_t rx_waddr, rx_raddr;
  urtb_pkg::tx_idx_t tx_waddr, tx_raddr;
  logic [7:0]        rx_rdata, tx_rdata;

  logic       slot_free;
  logic [6:0] rd_cnt;

  urtb_ram #(.WIDTH(8), .DEPTH(urtb_pkg::RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (data_r),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  urtb_ram #(.WIDTH(8), .DEPTH(urtb_pkg::TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (data_r),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // The output register can take a new result when it is empty or draining.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == urtb_pkg::S_IDLE);

  // Bytes a host read will pop: the smaller of the request and the fill level.
  assign rd_cnt = (maxc_r < 7'(rx_fill_r)) ? maxc_r : 7'(rx_fill_r);

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    data_nxt    = data_r;
    maxc_nxt    = maxc_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    rx_fill_nxt = rx_fill_r;
    rx_cr_nxt   = rx_cr_r;
    rem_nxt     = rem_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_fill_nxt = tx_fill_r;
    irq_nxt     = irq_r;

    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    rx_waddr = rx_tail_r;
    rx_raddr = rx_head_r;
    tx_waddr = tx_tail_r;
    tx_raddr = tx_head_r;

    load_out  = 1'b0;
    c_byte    = '0;
    c_bv      = 1'b0;
    c_last    = 1'b1;
    c_acc     = 1'b0;
    c_drop    = 1'b0;
    c_tx_byte = '0;
    c_tv      = 1'b0;

    case (state_r)
      urtb_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          data_nxt  = (in_func == urtb_pkg::FUNC_LINE) ? in_line_byte : in_write_byte;
          maxc_nxt  = in_max_count;
          state_nxt = urtb_pkg::S_EXEC;
        end
      end

      urtb_pkg::S_EXEC: begin
        if (slot_free) begin
          case (func_r)
            urtb_pkg::FUNC_LINE: begin
              // Store the line byte, or drop it when the receive FIFO is full.
              if (rx_fill_r == urtb_pkg::RX_FW'(urtb_pkg::RX_DEPTH)) begin
                c_drop = 1'b1;
              end else begin
                rx_we       = 1'b1;
                rx_tail_nxt = urtb_pkg::rx_next(rx_tail_r);
                rx_fill_nxt = rx_fill_r + urtb_pkg::RX_FW'(1);
                if (data_r == urtb_pkg::CR_BYTE) begin
                  rx_cr_nxt = rx_cr_r + urtb_pkg::RX_FW'(1);
                end
              end
              load_out  = 1'b1;
              state_nxt = urtb_pkg::S_IDLE;
            end
            urtb_pkg::FUNC_WRITE: begin
              // Queue the host byte if there is room; enable transmit handling anyway.
              if (tx_fill_r < urtb_pkg::TX_FW'(urtb_pkg::TX_DEPTH)) begin
                tx_we       = 1'b1;
                tx_tail_nxt = urtb_pkg::tx_next(tx_tail_r);
                tx_fill_nxt = tx_fill_r + urtb_pkg::TX_FW'(1);
                c_acc       = 1'b1;
              end
              irq_nxt   = 1'b1;
              load_out  = 1'b1;
              state_nxt = urtb_pkg::S_IDLE;
            end
            urtb_pkg::FUNC_READ: begin
              // An empty read answers at once; otherwise fetch the head byte.
              if (rd_cnt == 7'd0) begin
                load_out  = 1'b1;
                state_nxt = urtb_pkg::S_IDLE;
              end else begin
                rx_re     = 1'b1;
                rem_nxt   = urtb_pkg::RX_FW'(rd_cnt);
                state_nxt = urtb_pkg::S_RXPOP;
              end
            end
            urtb_pkg::FUNC_TXRDY: begin
              if (irq_r && (tx_fill_r != '0)) begin
                tx_re     = 1'b1;
                state_nxt = urtb_pkg::S_TXPOP;
              end else begin
                irq_nxt   = 1'b0;
                load_out  = 1'b1;
                state_nxt = urtb_pkg::S_IDLE;
              end
            end
            default: begin
              state_nxt = urtb_pkg::S_IDLE;
            end
          endcase
        end
      end

      urtb_pkg::S_RXPOP: begin
        // Hand out the fetched byte and, unless it is the last, fetch the next one in the same cycle.
        if (slot_free) begin
          c_byte      = rx_rdata;
          c_bv        = 1'b1;
          c_last      = (rem_r == urtb_pkg::RX_FW'(1));
          rx_head_nxt = urtb_pkg::rx_next(rx_head_r);
          rx_fill_nxt = rx_fill_r - urtb_pkg::RX_FW'(1);
          rem_nxt     = rem_r - urtb_pkg::RX_FW'(1);
          if (rx_rdata == urtb_pkg::CR_BYTE) begin
            rx_cr_nxt = rx_cr_r - urtb_pkg::RX_FW'(1);
          end
          load_out = 1'b1;
          if (rem_r == urtb_pkg::RX_FW'(1)) begin
            state_nxt = urtb_pkg::S_IDLE;
          end else begin
            rx_re    = 1'b1;
            rx_raddr = rx_head_nxt;
          end
        end
      end

      urtb_pkg::S_TXPOP: begin
        if (slot_free) begin
          c_tx_byte   = tx_rdata;
          c_tv        = 1'b1;
          tx_head_nxt = urtb_pkg::tx_next(tx_head_r);
          tx_fill_nxt = tx_fill_r - urtb_pkg::TX_FW'(1);
          load_out    = 1'b1;
          state_nxt   = urtb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = urtb_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urtb_pkg::S_IDLE;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_fill_r   <= '0;
      rx_cr_r     <= '0;
      rem_r       <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_fill_r   <= '0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_fill_r   <= rx_fill_nxt;
      rx_cr_r     <= rx_cr_nxt;
      rem_r       <= rem_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_fill_r   <= tx_fill_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload: no reset needed.
  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    data_r <= data_nxt;
    maxc_r <= maxc_nxt;
    if (load_out) begin
      res_byte_r    <= c_byte;
      res_bv_r      <= c_bv;
      res_last_r    <= c_last;
      res_acc_r     <= c_acc;
      res_drop_r    <= c_drop;
      res_tx_byte_r <= c_tx_byte;
      res_tv_r      <= c_tv;
      res_rxl_r     <= 7'(rx_fill_nxt);
      res_txl_r     <= 8'(tx_fill_nxt);
      res_lr_r      <= (rx_cr_nxt != '0);
      res_irq_r     <= irq_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = res_byte_r;
  assign out_byte_valid    = res_bv_r;
  assign out_last          = res_last_r;
  assign out_accepted      = res_acc_r;
  assign out_dropped       = res_drop_r;
  assign out_tx_byte       = res_tx_byte_r;
  assign out_tx_valid      = res_tv_r;
  assign out_rx_level      = res_rxl_r;
  assign out_tx_level      = res_txl_r;
  assign out_line_ready    = res_lr_r;
  assign out_tx_irq_enable = res_irq_r;

endmodule

FILE: sv/urtb_checker.sv
// Port-level checker for the UART ring buffer block, bound to the top level.
module urtb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_last,
  input logic       out_accepted,
  input logic       out_dropped,
  input logic       out_tx_valid,
  input logic [6:0] out_rx_level,
  input logic       out_line_ready,
  input logic       out_tx_irq_enable
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_rx_level))
    else $error("stalled result changed");

  // A popped receive byte carries no other event.
  a_rx_pop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> !out_tx_valid && !out_accepted && !out_dropped)
    else $error("receive pop mixed with other event");

  // A transmit pop happens only with transmit handling enabled.
  a_tx_pop_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_tx_irq_enable && out_last)
    else $error("transmit pop without enable");

  // A held carriage return means the receive FIFO is not empty and not overfull.
  a_line_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_ready |-> (out_rx_level != 7'd0)
      && (out_rx_level <= 7'(urtb_pkg::RX_DEPTH)))
    else $error("line ready with bad receive level");

  // A dropped line byte is reported only with a full receive FIFO.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_rx_level == 7'(urtb_pkg::RX_DEPTH))
    else $error("drop with room left");

endmodule

bind uart_rx_tx_ring_buffers urtb_checker u_urtb_checker (.*);
